// File: rtl/bev_pkg.sv
// shared types and constants of the button event recorder
package bev_pkg;

   localparam int STORE_DEPTH  = 512;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
   localparam int BUTTON_COUNT = 8;
   localparam int BUTTON_W     = $clog2(BUTTON_COUNT);
   localparam int TIME_W       = 32;
   localparam int INDEX_W      = 9;

   localparam logic [1:0] MODE_POLL   = 2'd0;
   localparam logic [1:0] MODE_TOGGLE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   localparam logic [2:0] KIND_PRESS   = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_READ    = 3'd3;
   localparam logic [2:0] KIND_TOGGLE  = 3'd4;

   typedef struct packed {
      logic [4:0]              pad;
      logic [INDEX_W-1:0]      entry_index;
      logic [TIME_W-1:0]       now_ms;
      logic [BUTTON_COUNT-1:0] buttons_raw;
      logic [1:0]              mode;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]          pad;
      logic                recording_on;
      logic                entry_valid;
      logic [TIME_W-1:0]   gap_ms;
      logic [TIME_W-1:0]   held_ms;
      logic [BUTTON_W-1:0] button;
   } rsp_payload_type;

   typedef struct packed {
      logic [BUTTON_W-1:0] button;
      logic [TIME_W-1:0]   held;
      logic [TIME_W-1:0]   gap;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      entry_type           data;
   } store_wr_type;

endpackage

// File: rtl/bev_store.sv
// entry store memory with registered read and write forwarding
module bev_store (
   input  logic                         clock,
   input  bev_pkg::store_wr_type        wr,
   input  logic                         rd_en,
   input  logic [bev_pkg::STORE_AW-1:0] rd_addr,
   output bev_pkg::entry_type           rd_data
);

   bev_pkg::entry_type mem [bev_pkg::STORE_DEPTH];
   bev_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/button_event_recorder_core.sv
// button event recorder: edge events, note store sequencer and result register
// result path: accepted transaction -> work slot register -> result register
// throughput: one result per cycle unless the result side stalls; a poll emits one
// result per event (up to nine), a quiet poll none; single-result ones go back to back
// reset: synchronous; clears recording, timers, buttons, write position and fill count;
// store contents are not cleared, entries at or past the fill count read as invalid
module button_event_recorder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // mode, buttons_raw, now_ms, entry_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // button, held_ms, gap_ms, entry_valid, recording_on
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);

   localparam int BC = bev_pkg::BUTTON_COUNT;
   localparam int BW = bev_pkg::BUTTON_W;
   localparam int TW = bev_pkg::TIME_W;
   localparam int CW = bev_pkg::CNT_W;
   localparam int IW = bev_pkg::INDEX_W;

   bev_pkg::req_payload_type req;
   bev_pkg::store_wr_type    store_wr;
   bev_pkg::entry_type       store_rd;

   logic          work_valid_ff, work_valid_in;
   logic          work_first_ff, work_first_in;
   logic [1:0]    work_mode_ff, work_mode_in;
   logic [BC-1:0] work_pressed_ff, work_pressed_in;
   logic [BC-1:0] work_pending_ff, work_pending_in;
   logic [TW-1:0] work_now_ff, work_now_in;
   logic [IW-1:0] work_index_ff, work_index_in;
   logic [BC-1:0] prev_buttons_ff, prev_buttons_in;
   logic          recording_ff, recording_in;
   logic [CW-1:0] wpos_ff, wpos_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [TW-1:0] last_note_ff, last_note_in;
   logic [TW-1:0] press_time_ff [BC];
   logic [TW-1:0] press_time_in [BC];

   logic                     rsp_valid_ff, rsp_valid_in;
   bev_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [2:0]               rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic          out_free, step_go, step_emit, step_last, req_accept;
   logic          full_now, has_change, store_ok, entry_ok;
   logic [BW-1:0] sel;
   logic [BC-1:0] pending_rest;
   logic [TW-1:0] ptime, held, gap;
   logic [CW-1:0] wpos_inc;

   assign req        = bev_pkg::req_payload_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_go    = work_valid_ff && out_free;
   assign req_tready = !work_valid_ff || (step_go && step_last);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      sel = '0;
      for (int i = BC - 1; i >= 0; i--) begin
         if (work_pending_ff[i]) begin
            sel = BW'(i);
         end
      end
   end

   assign has_change   = |work_pending_ff;
   assign pending_rest = work_pending_ff & (work_pending_ff - BC'(1));
   assign full_now     = work_first_ff && (wpos_ff >= CW'(bev_pkg::STORE_DEPTH));
   assign store_ok     = recording_ff && (wpos_ff < CW'(bev_pkg::STORE_DEPTH));
   assign ptime        = press_time_ff[sel];
   assign held         = work_now_ff - ptime;
   assign gap          = ptime - last_note_ff;
   assign wpos_inc     = wpos_ff + CW'(1);
   assign entry_ok     = CW'(work_index_ff) < fill_ff;

   // current step of the transaction in the work slot
   always_comb begin
      step_emit   = 1'b0;
      step_last   = 1'b1;
      rsp_kind_in = bev_pkg::KIND_PRESS;
      rsp_data_in = '0;
      rsp_data_in.recording_on = recording_ff;
      case (work_mode_ff)
         bev_pkg::MODE_POLL: begin
            if (full_now) begin
               step_emit   = 1'b1;
               step_last   = !has_change;
               rsp_kind_in = bev_pkg::KIND_FULL;
               rsp_data_in.recording_on = 1'b0;
            end else if (has_change) begin
               step_emit   = 1'b1;
               step_last   = (pending_rest == '0);
               rsp_kind_in = work_pressed_ff[sel] ? bev_pkg::KIND_PRESS
                                                  : bev_pkg::KIND_RELEASE;
               rsp_data_in.button = sel;
            end
         end
         bev_pkg::MODE_TOGGLE: begin
            step_emit   = 1'b1;
            rsp_kind_in = bev_pkg::KIND_TOGGLE;
            rsp_data_in.recording_on = !recording_ff;
         end
         bev_pkg::MODE_READ: begin
            step_emit   = 1'b1;
            rsp_kind_in = bev_pkg::KIND_READ;
            if (entry_ok) begin
               rsp_data_in.button      = store_rd.button;
               rsp_data_in.held_ms     = store_rd.held;
               rsp_data_in.gap_ms      = store_rd.gap;
               rsp_data_in.entry_valid = 1'b1;
            end
         end
         default: begin
            step_emit = 1'b0;
         end
      endcase
      rsp_last_in = step_last;
   end

   always_comb begin
      store_wr.en = step_go && (work_mode_ff == bev_pkg::MODE_POLL) && !full_now &&
                    has_change && !work_pressed_ff[sel] && store_ok;
      store_wr.addr        = wpos_ff[bev_pkg::STORE_AW-1:0];
      store_wr.data.button = sel;
      store_wr.data.held   = held;
      store_wr.data.gap    = gap;
   end

   bev_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (req_accept && (req.mode == bev_pkg::MODE_READ)),
      .rd_addr (bev_pkg::STORE_AW'(req.entry_index)),
      .rd_data (store_rd)
   );

   always_comb begin
      work_valid_in   = work_valid_ff;
      work_first_in   = work_first_ff;
      work_mode_in    = work_mode_ff;
      work_pressed_in = work_pressed_ff;
      work_pending_in = work_pending_ff;
      work_now_in     = work_now_ff;
      work_index_in   = work_index_ff;
      prev_buttons_in = prev_buttons_ff;
      recording_in    = recording_ff;
      wpos_in         = wpos_ff;
      fill_in         = fill_ff;
      last_note_in    = last_note_ff;
      press_time_in   = press_time_ff;
      if (step_go) begin
         case (work_mode_ff)
            bev_pkg::MODE_POLL: begin
               work_first_in = 1'b0;
               if (full_now) begin
                  wpos_in      = '0;
                  recording_in = 1'b0;
               end else if (has_change) begin
                  work_pending_in = pending_rest;
                  if (work_pressed_ff[sel]) begin
                     if (recording_ff) begin
                        press_time_in[sel] = work_now_ff;
                        last_note_in       = work_now_ff;
                     end
                  end else if (store_ok) begin
                     wpos_in      = wpos_inc;
                     fill_in      = wpos_inc;
                     last_note_in = work_now_ff;
                  end
               end
            end
            bev_pkg::MODE_TOGGLE: begin
               recording_in = !recording_ff;
               if (!recording_ff) begin
                  last_note_in = work_now_ff;
                  wpos_in      = '0;
                  fill_in      = '0;
                  for (int i = 0; i < BC; i++) begin
                     press_time_in[i] = work_now_ff;
                  end
               end
            end
            default: begin
               work_first_in = 1'b0;
            end
         endcase
         if (step_last) begin
            work_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         work_valid_in   = 1'b1;
         work_first_in   = 1'b1;
         work_mode_in    = req.mode;
         work_now_in     = req.now_ms;
         work_index_in   = req.entry_index;
         work_pressed_in = ~req.buttons_raw;
         work_pending_in = '0;
         if (req.mode == bev_pkg::MODE_POLL) begin
            work_pending_in = ~req.buttons_raw ^ prev_buttons_ff;
            prev_buttons_in = ~req.buttons_raw;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (step_go && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff   <= 1'b0;
         work_first_ff   <= 1'b0;
         work_mode_ff    <= bev_pkg::MODE_POLL;
         work_pending_ff <= '0;
         prev_buttons_ff <= '0;
         recording_ff    <= 1'b0;
         wpos_ff         <= '0;
         fill_ff         <= '0;
         last_note_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < BC; i++) begin
            press_time_ff[i] <= '0;
         end
      end else begin
         work_valid_ff   <= work_valid_in;
         work_first_ff   <= work_first_in;
         work_mode_ff    <= work_mode_in;
         work_pending_ff <= work_pending_in;
         prev_buttons_ff <= prev_buttons_in;
         recording_ff    <= recording_in;
         wpos_ff         <= wpos_in;
         fill_ff         <= fill_in;
         last_note_ff    <= last_note_in;
         rsp_valid_ff    <= rsp_valid_in;
         press_time_ff   <= press_time_in;
      end
   end

   always_ff @(posedge clock) begin
      work_pressed_ff <= work_pressed_in;
      work_now_ff     <= work_now_in;
      work_index_ff   <= work_index_in;
      if (step_go && step_emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: dv/tb_button_event_recorder_core.sv
// self-checking testbench for the button event recorder core
module tb_button_event_recorder_core;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 500;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 32;
   localparam int BW = bev_pkg::BUTTON_W;
   localparam int TW = bev_pkg::TIME_W;
   localparam int IW = bev_pkg::INDEX_W;

   typedef struct packed {
      logic [2:0]    kind;
      logic [BW-1:0] button;
      logic [TW-1:0] held_ms;
      logic [TW-1:0] gap_ms;
      logic          entry_valid;
      logic          recording_on;
      logic          last;
   } button_event_type;

   class button_event_scoreboard;
      bit [bev_pkg::BUTTON_COUNT-1:0] held_mask;
      bit                             recording;
      int unsigned                    write_pos;
      bit [TW-1:0]                    last_note_ms;
      bit [TW-1:0]                    press_ms [bev_pkg::BUTTON_COUNT];
      bev_pkg::entry_type             notes [bev_pkg::STORE_DEPTH];
      bit                             note_valid [bev_pkg::STORE_DEPTH];
      int unsigned                    written_span;
      int                             error_count;
      button_event_type               expected_q [$];

      function void push_event(logic [2:0] kind, logic [BW-1:0] button,
                               logic [TW-1:0] held, logic [TW-1:0] gap,
                               logic valid);
         button_event_type e;
         e.kind         = kind;
         e.button       = button;
         e.held_ms      = held;
         e.gap_ms       = gap;
         e.entry_valid  = valid;
         e.recording_on = recording;
         e.last         = 1'b0;
         expected_q.push_back(e);
      endfunction

      function void note_request(bev_pkg::req_payload_type req);
         bit [bev_pkg::BUTTON_COUNT-1:0] pressed;
         bit [bev_pkg::BUTTON_COUNT-1:0] changed;
         bit [TW-1:0]                    t;
         bit [TW-1:0]                    hold;
         int                             first;
         int                             b;
         first   = expected_q.size();
         pressed = ~req.buttons_raw;
         t       = req.now_ms;
         case (req.mode)
            bev_pkg::MODE_POLL: begin
               if (write_pos >= bev_pkg::STORE_DEPTH) begin
                  write_pos = 0;
                  recording = 1'b0;
                  push_event(bev_pkg::KIND_FULL, '0, '0, '0, 1'b0);
               end
               changed = pressed ^ held_mask;
               for (b = 0; b < bev_pkg::BUTTON_COUNT; b++) begin
                  if (changed[b]) begin
                     if (pressed[b]) begin
                        push_event(bev_pkg::KIND_PRESS, BW'(b), '0, '0, 1'b0);
                        if (recording) begin
                           press_ms[b]  = t;
                           last_note_ms = t;
                        end
                     end else begin
                        push_event(bev_pkg::KIND_RELEASE, BW'(b), '0, '0, 1'b0);
                        if (recording && write_pos < bev_pkg::STORE_DEPTH) begin
                           hold = t - press_ms[b];
                           notes[write_pos].button = BW'(b);
                           notes[write_pos].held   = hold;
                           notes[write_pos].gap    = t - last_note_ms - hold;
                           note_valid[write_pos]   = 1'b1;
                           write_pos++;
                           if (write_pos > written_span) written_span = write_pos;
                           last_note_ms = t;
                        end
                     end
                  end
               end
               held_mask = pressed;
            end
            bev_pkg::MODE_TOGGLE: begin
               recording = !recording;
               if (recording) begin
                  last_note_ms = t;
                  write_pos    = 0;
                  foreach (press_ms[i]) press_ms[i] = t;
                  foreach (note_valid[i]) note_valid[i] = 1'b0;
               end
               push_event(bev_pkg::KIND_TOGGLE, '0, '0, '0, 1'b0);
            end
            bev_pkg::MODE_READ: begin
               if (req.entry_index < bev_pkg::STORE_DEPTH && note_valid[req.entry_index])
                  push_event(bev_pkg::KIND_READ, notes[req.entry_index].button,
                             notes[req.entry_index].held, notes[req.entry_index].gap, 1'b1);
               else
                  push_event(bev_pkg::KIND_READ, '0, '0, '0, 1'b0);
            end
            default: ;
         endcase
         if (expected_q.size() > first) expected_q[$].last = 1'b1;
      endfunction

      function void compare_field(string name, logic [TW-1:0] want,
                                  logic [TW-1:0] got);
         if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(bev_pkg::rsp_payload_type data, logic [2:0] kind,
                                   logic last);
         button_event_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result kind %0d button %0d", kind, data.button);
            error_count++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("kind", TW'(e.kind), TW'(kind));
         compare_field("button", TW'(e.button), TW'(data.button));
         compare_field("held_ms", e.held_ms, data.held_ms);
         compare_field("gap_ms", e.gap_ms, data.gap_ms);
         compare_field("entry_valid", TW'(e.entry_valid), TW'(data.entry_valid));
         compare_field("recording_on", TW'(e.recording_on), TW'(data.recording_on));
         compare_field("last", TW'(e.last), TW'(last));
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   button_event_scoreboard sb;
   bit                     calm;
   bit [TW-1:0]            now_cursor;
   int                     sent_items;

   button_event_recorder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_button_event_recorder_core failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // mostly small steps, sometimes a long jump or an arbitrary time
   function automatic bit [TW-1:0] next_ms();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) now_cursor = now_cursor + $urandom_range(0, 50);
      else if (r < 95) now_cursor = now_cursor + $urandom_range(0, 100000);
      else now_cursor = $urandom;
      return now_cursor;
   endfunction

   task automatic send_request(logic [1:0] mode, bit [bev_pkg::BUTTON_COUNT-1:0] pressed,
                               bit [TW-1:0] t, bit [IW-1:0] index);
      bev_pkg::req_payload_type p;
      int                       idle;
      p             = '0;
      p.mode        = mode;
      p.buttons_raw = ~pressed;
      p.now_ms      = t;
      p.entry_index = index;
      idle = pick_gap();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      sb.note_request(p);
      if (mode != MODE_UNUSED) sent_items++;
   endtask

   task automatic poll(bit [bev_pkg::BUTTON_COUNT-1:0] pressed);
      send_request(bev_pkg::MODE_POLL, pressed, next_ms(), IW'($urandom));
   endtask

   task automatic read_random_entry();
      send_request(bev_pkg::MODE_READ, 8'($urandom), $urandom,
                   IW'($urandom_range(0, sb.written_span - 1)));
   endtask

   // result side: checks each transaction, stalls at random
   initial begin
      int stall;
      stall = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(bev_pkg::rsp_payload_type'(rsp_tdata), rsp_tuser, rsp_tlast);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   initial begin
      int                             iter;
      int                             fills;
      int                             next_fill;
      int                             room;
      int                             r;
      bit [bev_pkg::BUTTON_COUNT-1:0] mask;
      sb         = new();
      calm       = 1'b0;
      now_cursor = '0;
      sent_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_request(MODE_UNUSED, 8'h00, 32'd0, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'hFF, 32'd10, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h00, 32'd20, 9'h1FF);
      send_request(bev_pkg::MODE_POLL, 8'h00, 32'd30, 9'd0);
      send_request(bev_pkg::MODE_TOGGLE, 8'h00, 32'hFFFF_FFF0, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h01, 32'hFFFF_FFF8, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h81, 32'h0000_0005, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h80, 32'h0000_0010, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h00, 32'hFFFF_FFFF, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'hA5, 32'd100, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h5A, 32'd200, 9'd0);
      send_request(bev_pkg::MODE_READ, 8'hFF, 32'hFFFF_FFFF, 9'd0);
      send_request(bev_pkg::MODE_READ, 8'h00, 32'd0, 9'd1);
      send_request(bev_pkg::MODE_READ, 8'h00, 32'd0, 9'd5);
      send_request(bev_pkg::MODE_TOGGLE, 8'h00, 32'd300, 9'd0);
      send_request(bev_pkg::MODE_READ, 8'h00, 32'd0, 9'd3);
      send_request(bev_pkg::MODE_POLL, 8'h00, 32'd400, 9'd0);
      send_request(bev_pkg::MODE_TOGGLE, 8'h00, 32'd500, 9'd0);
      send_request(bev_pkg::MODE_READ, 8'h00, 32'd0, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'hFF, 32'd0, 9'd0);
      send_request(bev_pkg::MODE_POLL, 8'h00, 32'hFFFF_FFFF, 9'd0);
      send_request(bev_pkg::MODE_READ, 8'h00, 32'd0, 9'd7);
      send_request(bev_pkg::MODE_TOGGLE, 8'h00, 32'd0, 9'd0);

      // random part, with two runs that fill the store past capacity
      iter      = 0;
      fills     = 0;
      next_fill = 60;
      now_cursor = $urandom;
      while (sent_items < ITEM_TARGET) begin
         if (iter % 16 == 0) calm = ($urandom_range(0, 4) == 0);
         iter++;
         if (fills < 2 && sent_items >= next_fill) begin
            if (sb.recording)
               send_request(bev_pkg::MODE_TOGGLE, 8'($urandom), next_ms(), IW'($urandom));
            send_request(bev_pkg::MODE_TOGGLE, 8'($urandom), next_ms(), IW'($urandom));
            poll(8'h00);
            while (sb.write_pos < bev_pkg::STORE_DEPTH) begin
               room = bev_pkg::STORE_DEPTH - sb.write_pos;
               if (room < bev_pkg::BUTTON_COUNT) begin
                  mask = 8'hFF;
               end else begin
                  mask = ($urandom_range(0, 9) < 7) ? 8'hFF : 8'($urandom_range(1, 255));
                  if (room == bev_pkg::BUTTON_COUNT) mask[$urandom_range(0, 7)] = 1'b0;
               end
               poll(mask);
               poll(8'h00);
            end
            poll(8'($urandom));
            repeat (8) read_random_entry();
            fills++;
            next_fill = sent_items + 60;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               mask = 8'(1 << $urandom_range(0, 7));
               if ($urandom_range(0, 9) < 3) mask = mask | 8'($urandom);
               poll(sb.held_mask ^ mask);
            end else if (r < 60) begin
               poll(8'($urandom));
            end else if (r < 65) begin
               poll(sb.held_mask);
            end else if (r < 82 && sb.written_span > 0) begin
               read_random_entry();
            end else if (r < 92) begin
               send_request(bev_pkg::MODE_TOGGLE, 8'($urandom), next_ms(), IW'($urandom));
            end else if (r < 96) begin
               send_request(MODE_UNUSED, 8'($urandom), $urandom, IW'($urandom));
            end else begin
               poll(~sb.held_mask);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("tb_button_event_recorder_core passed");
      else
         $display("tb_button_event_recorder_core failed");
      $finish;
   end

endmodule
